// ===== hdl/sfi_pkg.sv =====
// Shared types, constants and register map of the seeded storage fault injector.
package sfi_pkg;

    // Mixer and draw constants.
    localparam logic [63:0] GOLDEN_INC   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] KILL_SALT    = 64'h0000_00C0_FFEE_1234;
    localparam logic [63:0] SHORT_OFFSET = 64'h0000_0000_5BD1_E995;
    localparam logic [63:0] SHORT_MUL    = 64'hD6E8_FEB8_6659_FD93;
    localparam logic [31:0] PPM_SCALE    = 32'd1000000;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_FAULT_ENABLE     = 3'd0;
    localparam logic [2:0] REG_SEED             = 3'd1;
    localparam logic [2:0] REG_POWER_CUT_ENABLE = 3'd2;
    localparam logic [2:0] REG_KILL_POINT       = 3'd3;
    localparam logic [2:0] REG_MAX_CALLS        = 3'd4;
    localparam logic [2:0] REG_ERROR_PPM        = 3'd5;
    localparam logic [2:0] REG_SHORT_PPM        = 3'd6;

    localparam logic [31:0] MAX_CALLS_RESET = 32'd64;

    // Command kinds.
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_PWRITE = 3'd1;
    localparam logic [2:0] REQ_RENAME = 3'd4;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_EIO   = 2'd1,
        VERDICT_SHORT = 2'd2,
        VERDICT_CUT   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic        fault_enable;
        logic [63:0] seed;
        logic        power_cut_enable;
        logic [31:0] kill_point_explicit;
        logic [31:0] max_calls;
        logic [19:0] error_ppm;
        logic [19:0] short_ppm;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

// ===== hdl/sfi_regs.sv =====
// Configuration register file with its APB-style access port.
module sfi_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfi_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sfi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sfi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output sfi_pkg::cfg_t                     cfg
);
    import sfi_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg           <= '0;
            cfg_reg.max_calls <= MAX_CALLS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FAULT_ENABLE:     cfg_reg.fault_enable        <= pwdata[0];
                REG_SEED:             cfg_reg.seed                <= pwdata;
                REG_POWER_CUT_ENABLE: cfg_reg.power_cut_enable    <= pwdata[0];
                REG_KILL_POINT:       cfg_reg.kill_point_explicit <= pwdata[31:0];
                REG_MAX_CALLS:        cfg_reg.max_calls           <= pwdata[31:0];
                REG_ERROR_PPM:        cfg_reg.error_ppm           <= pwdata[19:0];
                REG_SHORT_PPM:        cfg_reg.short_ppm           <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FAULT_ENABLE:     prdata = {63'd0, cfg_reg.fault_enable};
            REG_SEED:             prdata = cfg_reg.seed;
            REG_POWER_CUT_ENABLE: prdata = {63'd0, cfg_reg.power_cut_enable};
            REG_KILL_POINT:       prdata = {32'd0, cfg_reg.kill_point_explicit};
            REG_MAX_CALLS:        prdata = {32'd0, cfg_reg.max_calls};
            REG_ERROR_PPM:        prdata = {44'd0, cfg_reg.error_ppm};
            REG_SHORT_PPM:        prdata = {44'd0, cfg_reg.short_ppm};
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== hdl/sfi_mul.sv =====
// Low half of a 64x64 product, built from three passes through one 32x32 multiplier.
module sfi_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfi_pkg::mul_req_t req,
    output sfi_pkg::mul_rsp_t rsp
);
    import sfi_pkg::*;

    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_HI_LO = 2'd1;
    localparam logic [1:0] PH_LO_HI = 2'd2;
    localparam logic [1:0] PH_LAST  = 2'd3;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod_next;

    always_comb begin
        case (phase_reg)
            PH_LO_LO: begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            PH_HI_LO: begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            default: begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
        endcase
    end

    assign prod_next = {32'd0, op_a} * {32'd0, op_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LO_LO;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LO_LO;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Cross terms only reach the upper word; their upper halves fall off the top.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            case (phase_reg)
                PH_HI_LO: acc_reg <= prod_reg;
                PH_LO_HI, PH_LAST: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                default: begin
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

// ===== hdl/sfi_rem.sv =====
// Remainder of a 64-bit dividend by a nonzero 32-bit divisor, two quotient bits per cycle.
module sfi_rem (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfi_pkg::div_req_t req,
    output sfi_pkg::div_rsp_t rsp
);
    import sfi_pkg::*;

    logic [31:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] t1;
    logic [32:0] t2;
    logic [31:0] r1;
    logic [31:0] r2;

    // The partial remainder stays below the divisor, so 32 bits hold it.
    always_comb begin
        t1 = {rem_reg, dvd_reg[63]};
        if (t1 >= {1'b0, dvs_reg}) begin
            r1 = 32'(t1 - {1'b0, dvs_reg});
        end else begin
            r1 = t1[31:0];
        end
        t2 = {r1, dvd_reg[62]};
        if (t2 >= {1'b0, dvs_reg}) begin
            r2 = 32'(t2 - {1'b0, dvs_reg});
        end else begin
            r2 = t2[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= r2;
            dvd_reg <= {dvd_reg[61:0], 2'b00};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== hdl/seeded_storage_fault_injector_unit.sv =====
// Top level of the seeded storage fault injector: sequencer, result register and assertions.
//
// The block takes one storage command transaction at a time on the s_ stream and answers
// each with exactly one verdict transaction on the m_ stream. A command that arrives while
// the block is halted, or that is not eligible, goes straight to the emit state; its verdict
// is loaded into the output register once that register is free, and the block then goes
// back to idle to accept the next command. An eligible command runs up to three
// pseudo-random draws in turn (derived kill point, I/O error, short write); a draw that its
// rate or its configuration rules out is skipped. Each pass of the shared 64-bit multiply
// runs on a single 32x32 multiplier. The remainder unit retires two bits per cycle of the
// 64-bit mix value. The kill-point draw takes two multiply passes and the I/O error and
// short-write draws three passes each. Time spent waiting for a stalled output register
// adds to the time from one accepted command to the next. The block takes a new command as
// soon as its sequencer is free, even while the previous verdict still waits in the output
// register. After a power cut the block stays halted and answers every later command with
// a power-cut verdict until reset. Configuration registers are meant to be written only
// while no command is in flight.
module seeded_storage_fault_injector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Command stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfi_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] byte_count
    input  logic [sfi_pkg::S_TUSER_W-1:0]    s_tuser,  // [2:0] req_type, [3] file_is_regular
    // Verdict stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfi_pkg::M_TDATA_W-1:0]    m_tdata,  // [31:0] pass_bytes, [95:32] call_index
    output logic [sfi_pkg::M_TUSER_W-1:0]    m_tuser,  // [1:0] verdict
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfi_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sfi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sfi_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SELECT = 10'b00_0000_0010,
        S_ERR    = 10'b00_0000_0100,
        S_SHR    = 10'b00_0000_1000,
        S_PRE    = 10'b00_0001_0000,
        S_MIX    = 10'b00_0010_0000,
        S_MULA   = 10'b00_0100_0000,
        S_MULB   = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        JOB_KILL  = 2'd0,
        JOB_ERR   = 2'd1,
        JOB_SHORT = 2'd2
    } job_t;

    cfg_t     cfg;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t      state_reg,  state_next;
    job_t        job_reg,    job_next;
    logic [2:0]  kind_reg,   kind_next;
    logic [31:0] count_reg,  count_next;
    logic [63:0] ecount_reg, ecount_next;
    logic [63:0] idx_reg,    idx_next;
    logic [63:0] x_reg,      x_next;
    logic        halted_reg, halted_next;
    verdict_t    res_verdict_reg, res_verdict_next;
    logic [31:0] res_bytes_reg,   res_bytes_next;
    logic [63:0] res_idx_reg,     res_idx_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    verdict_t    m_verdict_reg;

    logic        eligible_in;
    logic        short_go;
    logic        load_out;
    logic [63:0] mix_in;
    logic [63:0] draw_base;
    logic [31:0] kill_range;
    logic [32:0] kill_derived;

    sfi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    sfi_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Renames only need the enable; every other kind also needs a regular file.
    assign eligible_in = cfg.fault_enable && (s_tuser[3] || (s_tuser[2:0] == REQ_RENAME));
    assign short_go    = ((kind_reg == REQ_WRITE) || (kind_reg == REQ_PWRITE))
                         && (count_reg > 32'd1) && (cfg.short_ppm != 20'd0);
    assign mix_in      = x_reg + GOLDEN_INC;
    assign draw_base   = (job_reg == JOB_ERR) ? cfg.seed : cfg.seed + SHORT_OFFSET;
    assign kill_range  = (cfg.max_calls == 32'd0) ? 32'd1 : cfg.max_calls;
    assign kill_derived = {1'b0, div_rsp.rem} + 33'd1;

    assign s_tready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);

    // Operand selection for the shared multiplier. The pre-multiply of the call index is
    // issued when the error or short-write draw is chosen; the two mixer products follow.
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (state_reg)
            S_ERR: begin
                mul_req.start = (cfg.error_ppm != 20'd0);
                mul_req.a     = idx_reg;
                mul_req.b     = GOLDEN_INC;
            end
            S_SHR: begin
                mul_req.start = short_go;
                mul_req.a     = idx_reg;
                mul_req.b     = SHORT_MUL;
            end
            S_MIX: begin
                mul_req.start = 1'b1;
                mul_req.a     = mix_in ^ (mix_in >> 30);
                mul_req.b     = MIX_MUL_A;
            end
            S_MULA: begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = mul_rsp.p ^ (mul_rsp.p >> 27);
                mul_req.b     = MIX_MUL_B;
            end
            default: begin
            end
        endcase
    end

    // The finished mix value goes straight into the remainder unit.
    assign div_req.start    = (state_reg == S_MULB) && mul_rsp.done;
    assign div_req.dividend = mul_rsp.p ^ (mul_rsp.p >> 31);
    assign div_req.divisor  = (job_reg == JOB_KILL) ? kill_range : PPM_SCALE;

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        kind_next        = kind_reg;
        count_next       = count_reg;
        ecount_next      = ecount_reg;
        idx_next         = idx_reg;
        x_next           = x_reg;
        halted_next      = halted_reg;
        res_verdict_next = res_verdict_reg;
        res_bytes_next   = res_bytes_reg;
        res_idx_next     = res_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser[2:0];
                    count_next = s_tdata;
                    if (halted_reg) begin
                        res_verdict_next = VERDICT_CUT;
                        res_bytes_next   = '0;
                        res_idx_next     = '0;
                        state_next       = S_EMIT;
                    end else if (eligible_in) begin
                        ecount_next = ecount_reg + 64'd1;
                        idx_next    = ecount_reg + 64'd1;
                        state_next  = S_SELECT;
                    end else begin
                        res_verdict_next = VERDICT_PASS;
                        res_bytes_next   = s_tdata;
                        res_idx_next     = '0;
                        state_next       = S_EMIT;
                    end
                end
            end
            S_SELECT: begin
                // An explicit kill point wins; otherwise, when power cuts are enabled, one is drawn from the seed.
                if (cfg.kill_point_explicit != 32'd0) begin
                    if (idx_reg == {32'd0, cfg.kill_point_explicit}) begin
                        res_verdict_next = VERDICT_CUT;
                        res_bytes_next   = '0;
                        res_idx_next     = idx_reg;
                        halted_next      = 1'b1;
                        state_next       = S_EMIT;
                    end else begin
                        state_next = S_ERR;
                    end
                end else if (cfg.power_cut_enable) begin
                    job_next   = JOB_KILL;
                    x_next     = cfg.seed ^ KILL_SALT;
                    state_next = S_MIX;
                end else begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                if (cfg.error_ppm == 20'd0) begin
                    state_next = S_SHR;
                end else begin
                    job_next   = JOB_ERR;
                    state_next = S_PRE;
                end
            end
            S_SHR: begin
                if (short_go) begin
                    job_next   = JOB_SHORT;
                    state_next = S_PRE;
                end else begin
                    res_verdict_next = VERDICT_PASS;
                    res_bytes_next   = count_reg;
                    res_idx_next     = idx_reg;
                    state_next       = S_EMIT;
                end
            end
            S_PRE: begin
                if (mul_rsp.done) begin
                    x_next     = draw_base ^ mul_rsp.p;
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                state_next = S_MULA;
            end
            S_MULA: begin
                if (mul_rsp.done) begin
                    state_next = S_MULB;
                end
            end
            S_MULB: begin
                if (mul_rsp.done) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    case (job_reg)
                        JOB_KILL: begin
                            if (idx_reg == {31'd0, kill_derived}) begin
                                res_verdict_next = VERDICT_CUT;
                                res_bytes_next   = '0;
                                res_idx_next     = idx_reg;
                                halted_next      = 1'b1;
                                state_next       = S_EMIT;
                            end else begin
                                state_next = S_ERR;
                            end
                        end
                        JOB_ERR: begin
                            if (div_rsp.rem < {12'd0, cfg.error_ppm}) begin
                                res_verdict_next = VERDICT_EIO;
                                res_bytes_next   = '0;
                                res_idx_next     = idx_reg;
                                state_next       = S_EMIT;
                            end else begin
                                state_next = S_SHR;
                            end
                        end
                        default: begin
                            res_idx_next = idx_reg;
                            state_next   = S_EMIT;
                            if (div_rsp.rem < {12'd0, cfg.short_ppm}) begin
                                res_verdict_next = VERDICT_SHORT;
                                res_bytes_next   = count_reg >> 1;
                            end else begin
                                res_verdict_next = VERDICT_PASS;
                                res_bytes_next   = count_reg;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ecount_reg  <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ecount_reg  <= ecount_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg         <= job_next;
        kind_reg        <= kind_next;
        count_reg       <= count_next;
        idx_reg         <= idx_next;
        x_reg           <= x_next;
        res_verdict_reg <= res_verdict_next;
        res_bytes_reg   <= res_bytes_next;
        res_idx_reg     <= res_idx_next;
        if (load_out) begin
            m_data_reg    <= {res_idx_reg, res_bytes_reg};
            m_verdict_reg <= res_verdict_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_verdict_reg;

    // The sequencer holds exactly one state at all times.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // Once a power cut has been given, only reset clears the halt.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt was released without reset");

    // A product only completes while the sequencer waits for one.
    a_mul_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == S_PRE || state_reg == S_MULA || state_reg == S_MULB))
        else $error("multiplier finished outside a multiply wait state");

    // A remainder only completes while the sequencer waits for one.
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("remainder unit finished outside its wait state");

endmodule
